>>> rtl/urxf_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the UART receive ring with automatic RTS.
// Operation codes, configuration register indexes and field widths; no dependencies.
package urxf_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int FUNC_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int MARK_W  = 6;
    localparam int FILL_W  = 6;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_FLUSH = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_MARK = 1'b0,
        CFG_LOW_MARK  = 1'b1
    } t_cfg_idx;

    localparam logic [MARK_W-1:0] HIGH_MARK_RST = 6'd48;
    localparam logic [MARK_W-1:0] LOW_MARK_RST  = 6'd16;
    localparam logic [BYTE_W-1:0] EMPTY_BYTE    = 8'hFF;

endpackage

>>> rtl/urxf_in_if.sv
`timescale 1ns / 1ps
// Input channel: one operation per beat (push, pop or flush) with the received byte.
// Depends on urxf_pkg for field widths.
interface urxf_in_if;
    logic                          valid;
    logic                          ready;
    logic [urxf_pkg::FUNC_W-1:0]   func;
    logic [urxf_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

>>> rtl/urxf_out_if.sv
`timescale 1ns / 1ps
// Result channel: read byte, empty flag, RTS level, overflow flag and fill count per beat.
// Depends on urxf_pkg for field widths.
interface urxf_out_if;
    logic                          valid;
    logic                          ready;
    logic [urxf_pkg::BYTE_W-1:0]   read_byte;
    logic                          was_empty;
    logic                          rts_out;
    logic                          overflowed;
    logic [urxf_pkg::FILL_W-1:0]   fill_count;

    modport source (output valid, output read_byte, output was_empty, output rts_out,
                    output overflowed, output fill_count, input ready);
    modport sink   (input valid, input read_byte, input was_empty, input rts_out,
                    input overflowed, input fill_count, output ready);
endinterface

>>> rtl/urxf_ring_ram.sv
`timescale 1ns / 1ps
// Byte storage of the receive ring: one write port, one read port, registered read data.
// No package dependency; depth is handed down from the top level.
module urxf_ring_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/uart_rx_fifo_rts_flow_control.sv
`timescale 1ns / 1ps
// UART receive ring with automatic RTS flow control. Top level.
// Depends on urxf_pkg, urxf_in_if, urxf_out_if and urxf_ring_ram.

// Unless stalled, one operation is accepted per cycle, its result in the next cycle;
// the output register lets a new beat enter in the same cycle the previous result is
// taken, so the sustained rate is one item per clock. A pop reads the ring memory at
// the accepting edge and the byte comes straight from the memory's read register,
// which holds until the next pop. The ring keeps at most DEPTH-1 bytes; a push on a
// full ring is dropped and sets a sticky overflow flag. RTS goes high when a push
// leaves the count at or above high_mark and low when a pop leaves it below
// low_mark; flush empties the ring, lowers RTS and keeps the overflow flag.
// A pop on an empty ring returns 0xFF with was_empty set. No clearing pass is needed
// after reset: only entries between the read and write index are ever read.
module uart_rx_fifo_rts_flow_control #(
    parameter int DEPTH = urxf_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    urxf_in_if.sink                          i_rx,
    urxf_out_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [urxf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [urxf_pkg::MARK_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW > urxf_pkg::FILL_W) ? AW : urxf_pkg::FILL_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0]                  r_wr_idx, n_wr_idx;
    logic [AW-1:0]                  r_rd_idx, n_rd_idx;
    logic                           r_rts, n_rts;
    logic                           r_ovf, n_ovf;
    logic [urxf_pkg::MARK_W-1:0]    r_high, r_low;
    logic                           r_out_valid;
    logic                           r_from_ram, n_from_ram;
    logic [urxf_pkg::BYTE_W-1:0]    r_byte_fix, n_byte_fix;
    logic                           r_was_empty, n_was_empty;
    logic [urxf_pkg::FILL_W-1:0]    r_fill;

    logic                           accept;
    logic                           ram_we, ram_re;
    logic [urxf_pkg::BYTE_W-1:0]    ram_rdata;
    logic [AW-1:0]                  wr_next, rd_next;
    logic [AW-1:0]                  held_new;
    logic [AW:0]                    held_wide;
    logic [CW-1:0]                  held_ext;
    logic                           full, empty;

    assign accept     = i_rx.valid && i_rx.ready;
    assign i_rx.ready = !r_out_valid || o_res.ready;

    assign wr_next = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + AW'(1);
    assign rd_next = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + AW'(1);
    assign full    = (wr_next == r_rd_idx);
    assign empty   = (r_rd_idx == r_wr_idx);

    always_comb begin
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_rts       = r_rts;
        n_ovf       = r_ovf;
        n_from_ram  = 1'b0;
        n_byte_fix  = '0;
        n_was_empty = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        unique case (urxf_pkg::t_func'(i_rx.func))
            urxf_pkg::FUNC_PUSH: begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    ram_we   = accept;
                    n_wr_idx = wr_next;
                end
            end
            urxf_pkg::FUNC_POP: begin
                if (empty) begin
                    n_byte_fix  = urxf_pkg::EMPTY_BYTE;
                    n_was_empty = 1'b1;
                end else begin
                    ram_re     = accept;
                    n_from_ram = 1'b1;
                    n_rd_idx   = rd_next;
                end
            end
            urxf_pkg::FUNC_FLUSH: begin
                n_wr_idx = '0;
                n_rd_idx = '0;
            end
            default: begin
            end
        endcase

        // count after the operation; the mark tests use it
        if (n_wr_idx >= n_rd_idx) begin
            held_wide = {1'b0, n_wr_idx} - {1'b0, n_rd_idx};
        end else begin
            held_wide = {1'b0, n_wr_idx} + (AW+1)'(DEPTH) - {1'b0, n_rd_idx};
        end
        held_new = held_wide[AW-1:0];
        held_ext = CW'(held_new);

        unique case (urxf_pkg::t_func'(i_rx.func))
            urxf_pkg::FUNC_PUSH: begin
                if (!full && !r_rts && (held_ext >= CW'(r_high))) begin
                    n_rts = 1'b1;
                end
            end
            urxf_pkg::FUNC_POP: begin
                if (r_rts && (held_ext < CW'(r_low))) begin
                    n_rts = 1'b0;
                end
            end
            urxf_pkg::FUNC_FLUSH: begin
                n_rts = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_rts       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            if (accept) begin
                r_wr_idx    <= n_wr_idx;
                r_rd_idx    <= n_rd_idx;
                r_rts       <= n_rts;
                r_ovf       <= n_ovf;
                r_fill      <= held_ext[urxf_pkg::FILL_W-1:0];
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, held while the beat waits
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_from_ram  <= n_from_ram;
            r_byte_fix  <= n_byte_fix;
            r_was_empty <= n_was_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= urxf_pkg::HIGH_MARK_RST;
            r_low  <= urxf_pkg::LOW_MARK_RST;
        end else if (i_cfg_we) begin
            unique case (urxf_pkg::t_cfg_idx'(i_cfg_idx))
                urxf_pkg::CFG_HIGH_MARK: r_high <= i_cfg_data;
                urxf_pkg::CFG_LOW_MARK:  r_low  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    urxf_ring_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (i_rx.rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign o_res.valid      = r_out_valid;
    assign o_res.read_byte  = r_from_ram ? ram_rdata : r_byte_fix;
    assign o_res.was_empty  = r_was_empty;
    assign o_res.rts_out    = r_rts;
    assign o_res.overflowed = r_ovf;
    assign o_res.fill_count = r_fill;

endmodule

>>> verif/tb_uart_rx_fifo_rts_flow_control.sv
`timescale 1ns / 1ps
// Testbench for the UART receive ring with automatic RTS: push, pop and flush beats in,
// status beats checked field by field against a local ring model with its own marks.
// Depends on urxf_pkg, urxf_in_if, urxf_out_if and uart_rx_fifo_rts_flow_control.
module tb_uart_rx_fifo_rts_flow_control;
    import urxf_pkg::*;

    localparam int RING_DEPTH     = DEPTH_DEFAULT;
    localparam int PTR_W          = $clog2(RING_DEPTH);
    localparam int IDLE_PCT       = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              was_empty;
        logic              rts_out;
        logic              overflowed;
        logic [FILL_W-1:0] fill_count;
    } t_ring_status;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    t_cfg_idx          cfg_idx;
    logic [MARK_W-1:0] cfg_data;

    urxf_in_if  rx_if();
    urxf_out_if res_if();

    uart_rx_fifo_rts_flow_control dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_rx       (rx_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // ring model
    logic [BYTE_W-1:0] ring_mdl [RING_DEPTH];
    logic [PTR_W-1:0]  wr_ptr = '0;
    logic [PTR_W-1:0]  rd_ptr = '0;
    logic              rts_mdl = 1'b0;
    logic              ovf_mdl = 1'b0;
    logic [MARK_W-1:0] high_mark_mdl = HIGH_MARK_RST;
    logic [MARK_W-1:0] low_mark_mdl  = LOW_MARK_RST;
    t_ring_status      status_due[$];

    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int n_errors = 0;
    int n_results = 0;
    int n_push = 0;
    int n_drop = 0;
    int n_pop = 0;
    int n_empty = 0;
    int n_flush = 0;
    int n_rts_rise = 0;
    int n_holds = 0;
    int peak_fill = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [PTR_W-1:0] ring_count();
        return wr_ptr - rd_ptr;
    endfunction

    // Apply one operation to the ring model and queue the status beat it yields.
    task automatic model_ring_op(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b);
        t_ring_status     st;
        logic [PTR_W-1:0] nxt;
        st  = '0;
        nxt = wr_ptr + PTR_W'(1);
        case (f)
            FUNC_PUSH: begin
                n_push++;
                if (nxt == rd_ptr) begin
                    ovf_mdl = 1'b1;
                    n_drop++;
                end else begin
                    ring_mdl[wr_ptr] = b;
                    wr_ptr = nxt;
                    if (!rts_mdl && ring_count() >= high_mark_mdl) begin
                        rts_mdl = 1'b1;
                        n_rts_rise++;
                    end
                end
            end
            FUNC_POP: begin
                n_pop++;
                if (rd_ptr != wr_ptr) begin
                    st.read_byte = ring_mdl[rd_ptr];
                    rd_ptr = rd_ptr + PTR_W'(1);
                end else begin
                    st.read_byte = EMPTY_BYTE;
                    st.was_empty = 1'b1;
                    n_empty++;
                end
                // the low mark test runs even when the pop found nothing
                if (rts_mdl && ring_count() < low_mark_mdl) rts_mdl = 1'b0;
            end
            FUNC_FLUSH: begin
                n_flush++;
                wr_ptr  = '0;
                rd_ptr  = '0;
                rts_mdl = 1'b0;
            end
            default: ;
        endcase
        if (int'(ring_count()) > peak_fill) peak_fill = int'(ring_count());
        st.rts_out    = rts_mdl;
        st.overflowed = ovf_mdl;
        st.fill_count = FILL_W'(ring_count());
        status_due.push_back(st);
    endtask

    // Offer one beat, idling first at random; valid stays high for a following beat.
    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.func    <= f;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        model_ring_op(f, b);
    endtask

    // Drain the block, then write both marks on back-to-back edges.
    task automatic write_marks(input logic [MARK_W-1:0] hi, input logic [MARK_W-1:0] lo);
        rx_if.valid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HIGH_MARK;
        cfg_data <= hi;
        @(posedge clk);
        high_mark_mdl = hi;
        cfg_idx  <= CFG_LOW_MARK;
        cfg_data <= lo;
        @(posedge clk);
        low_mark_mdl = lo;
        cfg_we <= 1'b0;
    endtask

    task automatic field_check(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    task automatic check_status();
        t_ring_status want;
        if (status_due.size() == 0) begin
            $error("result beat with nothing expected: read_byte %0h fill_count %0d",
                   res_if.read_byte, res_if.fill_count);
            n_errors++;
        end else begin
            want = status_due.pop_front();
            n_results++;
            field_check("read_byte",  want.read_byte,  res_if.read_byte);
            field_check("was_empty",  8'(want.was_empty),  8'(res_if.was_empty));
            field_check("rts_out",    8'(want.rts_out),    8'(res_if.rts_out));
            field_check("overflowed", 8'(want.overflowed), 8'(res_if.overflowed));
            field_check("fill_count", 8'(want.fill_count), 8'(res_if.fill_count));
        end
    endtask

    // Receiver: check the beat taken at this edge, then pick the next ready level.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) check_status();
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                n_holds++;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !(stall_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (rx_if.valid && rx_if.ready) ||
            (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reset marks: empty reads, byte order, the unused operation code and flush.
    task automatic test_empty_and_order();
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_PUSH, 8'h00);
        send_op(FUNC_PUSH, 8'hFF);
        send_op(FUNC_PUSH, 8'h5A);
        send_op(FUNC_PUSH, 8'hA5);
        send_op(FUNC_POP, 8'hFF);
        send_op(FUNC_UNUSED, 8'h77);
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_FLUSH, 8'hFF);
        send_op(FUNC_PUSH, 8'h33);
        send_op(FUNC_FLUSH, 8'h00);
        send_op(FUNC_POP, 8'h00);
    endtask

    // RTS raise and release around small marks, including release on an empty pop.
    task automatic test_rts_marks();
        write_marks(6'd3, 6'd2);
        repeat (4) send_op(FUNC_PUSH, 8'($urandom_range(255)));
        repeat (3) send_op(FUNC_POP, 8'($urandom_range(255)));
        repeat (2) send_op(FUNC_PUSH, 8'($urandom_range(255)));
        send_op(FUNC_FLUSH, 8'h00);
        write_marks(6'd1, 6'd0);
        send_op(FUNC_PUSH, 8'h81);
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_POP, 8'h00);
        // ring empty with RTS high: a pop must now release it
        write_marks(6'd1, 6'd1);
        send_op(FUNC_POP, 8'h00);
        write_marks(6'd0, 6'd63);
        send_op(FUNC_PUSH, 8'h18);
        send_op(FUNC_POP, 8'h00);
        send_op(FUNC_POP, 8'h00);
    endtask

    // Fill to DEPTH-1, drop two bytes, drain past empty, flush keeps the sticky flag.
    task automatic test_overflow();
        write_marks(6'd63, 6'd63);
        repeat (RING_DEPTH + 1) send_op(FUNC_PUSH, 8'($urandom_range(255)));
        repeat (RING_DEPTH) send_op(FUNC_POP, 8'($urandom_range(255)));
        send_op(FUNC_PUSH, 8'hC3);
        send_op(FUNC_FLUSH, 8'h00);
        send_op(FUNC_POP, 8'h00);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        write_marks(HIGH_MARK_RST, LOW_MARK_RST);
        hold_req = 1'b1;
        repeat (60) send_op($urandom_range(1) ? FUNC_PUSH : FUNC_POP,
                            8'($urandom_range(255)));
    endtask

    // Bursts that lean toward filling, draining or neither, with rare flushes.
    task automatic random_bursts(input int n_items);
        int left;
        int len;
        int push_pm;
        int roll;
        left = n_items;
        while (left > 0) begin
            case ($urandom_range(2))
                0:       push_pm = 900;
                1:       push_pm = 100;
                default: push_pm = 500;
            endcase
            len = $urandom_range(20, 80);
            if (len > left) len = left;
            left -= len;
            repeat (len) begin
                roll = $urandom_range(999);
                if (roll < 5)
                    send_op(FUNC_FLUSH, 8'($urandom_range(255)));
                else if (roll < 5 + push_pm)
                    send_op(FUNC_PUSH, 8'($urandom_range(255)));
                else
                    send_op(FUNC_POP, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_random();
        random_bursts(270);
        write_marks(6'd63, 6'd0);
        random_bursts(270);
        // one phase at full rate on both sides
        write_marks(6'd0, 6'd63);
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        random_bursts(270);
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        write_marks(6'd32, 6'd32);
        random_bursts(270);
        write_marks(6'd10, 6'd50);
        random_bursts(270);
        write_marks(MARK_W'($urandom_range(63)), MARK_W'($urandom_range(63)));
        random_bursts(270);
    endtask

    initial begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_HIGH_MARK;
        cfg_data      <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.func    <= FUNC_PUSH;
        rx_if.rx_byte <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_order();
        test_rts_marks();
        test_overflow();
        test_backpressure();
        test_random();

        rx_if.valid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Ran %0d pushes (%0d dropped on a full ring), %0d pops (%0d on empty), %0d flushes",
                 n_push, n_drop, n_pop, n_empty, n_flush);
        $display("Checked %0d status beats; peak fill %0d, %0d RTS raises, %0d long receiver holds",
                 n_results, peak_fill, n_rts_rise, n_holds);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
